// ===== rtl/tepq_pkg.sv =====
// Shared types and constants for the timed event priority queue.
package tepq_pkg;

    localparam int EVT_TIME_W = 32;
    localparam int OCC_W      = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic                  event_type;
        logic [EVT_TIME_W-1:0] event_time;
    } cmd_item_t;

    typedef struct packed {
        logic                  popped_valid;
        logic                  popped_type;
        logic [EVT_TIME_W-1:0] popped_time;
        logic                  overflow;
        logic                  underflow;
        logic [OCC_W-1:0]      occupancy;
    } rsp_item_t;

    // Per-cycle operation broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic pop;
        logic event_type;
    } cell_op_t;

endpackage

// ===== rtl/tepq_cmd_if.sv =====
// Command channel: valid/ready handshake carrying one insert or pop item.
interface tepq_cmd_if;
    import tepq_pkg::*;

    logic      valid;
    logic      ready;
    cmd_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/tepq_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one result item.
interface tepq_rsp_if;
    import tepq_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/tepq_cell.sv =====
// One queue slot: holds an event and does compare-and-shift with its neighbors.
module tepq_cell #(
    parameter int TIME_BITS = 32
) (
    input  logic                  clk,
    input  tepq_pkg::cell_op_t    op,
    input  logic [TIME_BITS-1:0]  new_time,
    input  logic                  occupied,
    input  logic                  left_le,
    input  logic [TIME_BITS-1:0]  left_time,
    input  logic                  left_type,
    input  logic [TIME_BITS-1:0]  right_time,
    input  logic                  right_type,
    output logic                  le,
    output logic [TIME_BITS-1:0]  slot_time,
    output logic                  slot_type
);
    import tepq_pkg::*;

    logic [TIME_BITS-1:0] time_reg;
    logic [TIME_BITS-1:0] time_next;
    logic                 type_reg;
    logic                 type_next;

    // On insert, slot stays put when it holds an event not later than the new one.
    assign le        = occupied && (time_reg <= new_time);
    assign slot_time = time_reg;
    assign slot_type = type_reg;

    always_comb
    begin
        time_next = time_reg;
        type_next = type_reg;
        if (op.pop)
        begin
            time_next = right_time;
            type_next = right_type;
        end
        else if (op.ins && !le)
        begin
            if (left_le)
            begin
                time_next = new_time;
                type_next = op.event_type;
            end
            else
            begin
                time_next = left_time;
                type_next = left_type;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.ins || op.pop)
        begin
            time_reg <= time_next;
            type_reg <= type_next;
        end
    end

endmodule

// ===== rtl/timed_event_priority_queue_unit.sv =====
// Top level of the timed event priority queue: cell row, count and result register.
//
//   channel | dir | payload                                             | handshake
//   cmd     | in  | kind, event_type, event_time                        | valid/ready
//   rsp     | out | popped_valid/type/time, overflow, underflow, occup. | valid/ready
//
// One item per cycle while cmd.ready is high; its result is registered on accept.
// The rate is set by the compare-and-shift done in every cell at once.
// Reset clears the event count and the result valid; slot contents stay undefined.
// cmd.ready is high while the result register is empty or being taken this cycle.
module timed_event_priority_queue_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    tepq_cmd_if.sink    cmd,
    tepq_rsp_if.source  rsp
);
    import tepq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 rsp_valid_reg;
    rsp_item_t            rsp_item_reg;
    rsp_item_t            rsp_item_next;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic [TIME_BITS-1:0] new_time;
    cell_op_t             op;

    logic                 cell_le   [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] cell_time [QUEUE_DEPTH];
    logic                 cell_type [QUEUE_DEPTH];

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign new_time  = TIME_BITS'(cmd.item.event_time);

    assign op.ins        = accept && (cmd.item.kind == OP_INSERT) && !full;
    assign op.pop        = accept && (cmd.item.kind == OP_POP) && !empty;
    assign op.event_type = cmd.item.event_type;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic                 l_le;
            logic [TIME_BITS-1:0] l_time;
            logic                 l_type;
            logic [TIME_BITS-1:0] r_time;
            logic                 r_type;

            if (gi == 0)
            begin : g_head
                assign l_le   = 1'b1;
                assign l_time = new_time;
                assign l_type = cmd.item.event_type;
            end
            else
            begin : g_body
                assign l_le   = cell_le[gi-1];
                assign l_time = cell_time[gi-1];
                assign l_type = cell_type[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign r_time = cell_time[gi];
                assign r_type = cell_type[gi];
            end
            else
            begin : g_next
                assign r_time = cell_time[gi+1];
                assign r_type = cell_type[gi+1];
            end

            tepq_cell #(
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .clk        (clk),
                .op         (op),
                .new_time   (new_time),
                .occupied   (CNT_W'(gi) < count_reg),
                .left_le    (l_le),
                .left_time  (l_time),
                .left_type  (l_type),
                .right_time (r_time),
                .right_type (r_type),
                .le         (cell_le[gi]),
                .slot_time  (cell_time[gi]),
                .slot_type  (cell_type[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (op.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (op.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        rsp_item_next              = '0;
        rsp_item_next.popped_valid = op.pop;
        rsp_item_next.popped_type  = op.pop ? cell_type[0] : 1'b0;
        rsp_item_next.popped_time  = op.pop ? EVT_TIME_W'(cell_time[0]) : '0;
        rsp_item_next.overflow     = (cmd.item.kind == OP_INSERT) && full;
        rsp_item_next.underflow    = (cmd.item.kind == OP_POP) && empty;
        rsp_item_next.occupancy    = OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result with each accepted item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_item_reg <= rsp_item_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.item  = rsp_item_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("event count beyond queue depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        op.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the queue");

    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        op.pop |=> rsp.item.popped_time == EVT_TIME_W'($past(cell_time[0])))
        else $error("pop did not return the head event");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.item.popped_valid && (rsp.item.underflow || rsp.item.overflow)))
        else $error("popped entry flagged as error");
`endif

endmodule

// ===== sim/tb_timed_event_priority_queue_unit.sv =====
// Testbench for the timed event priority queue: directed and random insert/pop items.
`timescale 1ns / 100ps

import tepq_pkg::*;

class event_order_board;
    localparam int SLOTS = 16;

    logic [EVT_TIME_W-1:0] slot_time [SLOTS];
    logic                  slot_type [SLOTS];
    int                    event_count;
    rsp_item_t             due_results [$];
    int                    mismatches;

    function new();
        event_count = 0;
        mismatches  = 0;
    endfunction

    // Apply one accepted command to the sorted list and queue the result it causes.
    function void note_command(cmd_item_t c);
        rsp_item_t r;
        int        pos;
        r = '0;
        if (c.kind == OP_INSERT) begin
            if (event_count == SLOTS) begin
                r.overflow = 1'b1;
            end
            else begin
                pos = 0;
                // Equal times go behind, so arrival order holds among ties.
                while (pos < event_count && slot_time[pos] <= c.event_time)
                    pos++;
                for (int i = event_count; i > pos; i--) begin
                    slot_time[i] = slot_time[i-1];
                    slot_type[i] = slot_type[i-1];
                end
                slot_time[pos] = c.event_time;
                slot_type[pos] = c.event_type;
                event_count++;
            end
        end
        else begin
            if (event_count == 0) begin
                r.underflow = 1'b1;
            end
            else begin
                r.popped_valid = 1'b1;
                r.popped_type  = slot_type[0];
                r.popped_time  = slot_time[0];
                for (int i = 1; i < event_count; i++) begin
                    slot_time[i-1] = slot_time[i];
                    slot_type[i-1] = slot_type[i];
                end
                event_count--;
            end
        end
        r.occupancy = event_count[OCC_W-1:0];
        due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(rsp_item_t got);
        rsp_item_t want;
        if (due_results.size() == 0) begin
            $display("%0t: result with nothing due: expected none actual %h", $time, got);
            mismatches++;
            return;
        end
        want = due_results.pop_front();
        compare_field("popped_valid", 32'(want.popped_valid), 32'(got.popped_valid));
        compare_field("popped_type",  32'(want.popped_type),  32'(got.popped_type));
        compare_field("popped_time",  32'(want.popped_time),  32'(got.popped_time));
        compare_field("overflow",     32'(want.overflow),     32'(got.overflow));
        compare_field("underflow",    32'(want.underflow),    32'(got.underflow));
        compare_field("occupancy",    32'(want.occupancy),    32'(got.occupancy));
    endfunction
endclass

module tb_timed_event_priority_queue_unit;

    localparam int   QUEUE_SLOTS   = 16;
    localparam int   RANDOM_ITEMS  = 1950;
    localparam logic EVT_ARRIVAL   = 1'b0;
    localparam logic EVT_DEPARTURE = 1'b1;
    localparam logic [EVT_TIME_W-1:0] TIME_MAX = '1;

    logic clk;
    logic rst_n;

    tepq_cmd_if cmd_ch ();
    tepq_rsp_if rsp_ch ();

    timed_event_priority_queue_unit #(
        .QUEUE_DEPTH(QUEUE_SLOTS),
        .TIME_BITS  (EVT_TIME_W)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .rsp  (rsp_ch)
    );

    event_order_board board;
    int               burst_left;
    int               stall_mode;
    int               stall_left;
    int               stall_tick;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: switch among steady, light, heavy and periodic stall patterns.
    always @(negedge clk)
    begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(30, 200);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= (stall_tick % 3 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready)
                board.note_command(cmd_ch.item);
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_result(rsp_ch.item);
        end
    end

    function automatic cmd_item_t make_cmd(logic kind, logic etype, logic [EVT_TIME_W-1:0] t);
        cmd_item_t c;
        c.kind       = kind;
        c.event_type = etype;
        c.event_time = t;
        return c;
    endfunction

    // Hold the item until accepted; open a new burst after a random gap.
    task automatic push_cmd(cmd_item_t c);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) begin
                @(negedge clk);
                cmd_ch.valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 20);
        end
        @(negedge clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.item  <= c;
        do @(posedge clk); while (!cmd_ch.ready);
        burst_left--;
    endtask

    function automatic logic [EVT_TIME_W-1:0] pick_time(bit narrow, logic [EVT_TIME_W-1:0] base);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return ($urandom_range(0, 1) != 0) ? TIME_MAX : '0;
        if (narrow)
            return base + $urandom_range(0, 7);
        return $urandom;
    endfunction

    initial
    begin
        int                    sent;
        int                    seg_len;
        int                    insert_pct;
        bit                    narrow;
        logic [EVT_TIME_W-1:0] base;
        logic                  kind;

        board        = new();
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.item  = '0;
        rsp_ch.ready = 1'b0;
        burst_left   = 0;
        stall_mode   = 0;
        stall_left   = 0;
        stall_tick   = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty pop, ties (also against the head), extremes, full and overflow.
        push_cmd(make_cmd(OP_POP,    EVT_ARRIVAL,   '0));
        push_cmd(make_cmd(OP_INSERT, EVT_ARRIVAL,   32'd5));
        push_cmd(make_cmd(OP_INSERT, EVT_DEPARTURE, 32'd5));
        push_cmd(make_cmd(OP_INSERT, EVT_DEPARTURE, 32'd0));
        push_cmd(make_cmd(OP_INSERT, EVT_ARRIVAL,   32'd0));
        push_cmd(make_cmd(OP_INSERT, EVT_DEPARTURE, TIME_MAX));
        push_cmd(make_cmd(OP_INSERT, EVT_ARRIVAL,   TIME_MAX));
        push_cmd(make_cmd(OP_INSERT, EVT_ARRIVAL,   32'd7));
        push_cmd(make_cmd(OP_INSERT, EVT_DEPARTURE, 32'd3));
        push_cmd(make_cmd(OP_INSERT, EVT_ARRIVAL,   32'd5));
        push_cmd(make_cmd(OP_INSERT, EVT_DEPARTURE, 32'h8000_0000));
        push_cmd(make_cmd(OP_INSERT, EVT_ARRIVAL,   32'd1));
        push_cmd(make_cmd(OP_INSERT, EVT_DEPARTURE, 32'hAAAA_AAAA));
        push_cmd(make_cmd(OP_INSERT, EVT_ARRIVAL,   32'h5555_5555));
        push_cmd(make_cmd(OP_INSERT, EVT_DEPARTURE, 32'd6));
        push_cmd(make_cmd(OP_INSERT, EVT_ARRIVAL,   32'd4));
        push_cmd(make_cmd(OP_INSERT, EVT_DEPARTURE, 32'd2));
        push_cmd(make_cmd(OP_INSERT, EVT_ARRIVAL,   32'd9));
        push_cmd(make_cmd(OP_INSERT, EVT_DEPARTURE, 32'd0));
        repeat (4) push_cmd(make_cmd(OP_POP, EVT_DEPARTURE, TIME_MAX));

        // Random: segments that lean toward filling, draining or neither.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            seg_len = $urandom_range(8, 60);
            case ($urandom_range(0, 2))
                0:       insert_pct = 80;
                1:       insert_pct = 20;
                default: insert_pct = 50;
            endcase
            narrow = ($urandom_range(0, 1) != 0);
            base   = $urandom;
            repeat (seg_len) begin
                kind = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
                push_cmd(make_cmd(kind, 1'($urandom_range(0, 1)), pick_time(narrow, base)));
                sent++;
            end
        end
        @(negedge clk);
        cmd_ch.valid <= 1'b0;

        while (board.due_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== timed_event_priority_queue_unit.f =====
rtl/tepq_pkg.sv
rtl/tepq_cmd_if.sv
rtl/tepq_rsp_if.sv
rtl/tepq_cell.sv
rtl/timed_event_priority_queue_unit.sv
sim/tb_timed_event_priority_queue_unit.sv
